FILE: rtl/ksub_pkg.sv
package ksub_pkg;

  // Mapping table geometry
  localparam int unsigned ALPHABET_SIZE = 52;
  localparam int unsigned LETTER_COUNT  = 26;
  localparam int unsigned POS_W         = $clog2(ALPHABET_SIZE);
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_INDEX_W   = 3;
  localparam int unsigned BYTES_PER_WORD = CFG_DATA_W / 8;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_6 = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LEN    = 3'd7;

  // Direction codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Character codes
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  typedef logic [7:0] byte_t;

  // Key table and active length, as held by the register file
  typedef struct packed {
    logic [ALPHABET_SIZE-1:0][7:0] key;
    logic [LEN_W-1:0]              len;
  } key_cfg_t;

  // Alphabet letter at a table position: A..Z then a..z
  function automatic byte_t alpha_at(input logic [POS_W-1:0] pos);
    byte_t res;
    if (pos < POS_W'(LETTER_COUNT)) begin
      res = CHAR_UPPER_A + 8'(pos);
    end else begin
      res = CHAR_LOWER_A + 8'(pos) - 8'(LETTER_COUNT);
    end
    return res;
  endfunction

endpackage

FILE: rtl/ksub_keyregs.sv
module ksub_keyregs
  import ksub_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output key_cfg_t               key_cfg
);

  logic [ALPHABET_SIZE-1:0][7:0] key;
  logic [LEN_W-1:0]              len;

  // Write key bytes a word at a time; the last word carries only four bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      len <= '0;
    end else if (cfg_we) begin
      for (int k = 0; k < ALPHABET_SIZE; k++) begin
        if (cfg_index == CFG_INDEX_W'(k / BYTES_PER_WORD)) begin
          key[k] <= cfg_wdata[8*(k % BYTES_PER_WORD) +: 8];
        end
      end
      if (cfg_index == REG_KEY_LEN) begin
        len <= cfg_wdata[LEN_W-1:0];
      end
    end
  end

  assign key_cfg.key = key;
  assign key_cfg.len = len;

endmodule

FILE: rtl/ksub_xlat.sv
module ksub_xlat
  import ksub_pkg::*;
(
  input  key_cfg_t   key_cfg,
  input  logic       mode,
  input  logic [7:0] in_char,
  output logic [7:0] mapped_char
);

  logic [LEN_W-1:0]         len_sat;
  logic [ALPHABET_SIZE-1:0] active;
  logic [ALPHABET_SIZE-1:0] hits;
  logic [ALPHABET_SIZE-1:0] first_hit;
  logic [POS_W-1:0]         dec_pos;
  logic [POS_W-1:0]         enc_pos;
  logic                     enc_letter;
  logic [7:0]               enc_key;
  logic [7:0]               enc_char;
  logic [7:0]               dec_char;

  // Saturate the active length to the table size
  assign len_sat = (key_cfg.len > LEN_W'(ALPHABET_SIZE)) ? LEN_W'(ALPHABET_SIZE) : key_cfg.len;

  // Compare every key byte against the input in parallel
  always_comb begin
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      active[i] = (LEN_W'(i) < len_sat);
      hits[i]   = active[i] && (key_cfg.key[i] == in_char);
    end
  end

  // Keep the lowest matching position and turn it into an index
  assign first_hit = hits & (~hits + ALPHABET_SIZE'(1));

  always_comb begin
    dec_pos = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      dec_pos = dec_pos | (first_hit[i] ? POS_W'(i) : '0);
    end
  end

  assign dec_char = (hits != '0) ? alpha_at(dec_pos) : in_char;

  // Encode: alphabet position follows directly from the letter code
  always_comb begin
    enc_letter = 1'b0;
    enc_pos    = '0;
    if (in_char >= CHAR_UPPER_A && in_char <= CHAR_UPPER_Z) begin
      enc_letter = 1'b1;
      enc_pos    = POS_W'(in_char - CHAR_UPPER_A);
    end else if (in_char >= CHAR_LOWER_A && in_char <= CHAR_LOWER_Z) begin
      enc_letter = 1'b1;
      enc_pos    = POS_W'(in_char - CHAR_LOWER_A + 8'(LETTER_COUNT));
    end
  end

  assign enc_key  = key_cfg.key[enc_pos];
  assign enc_char = (enc_letter && active[enc_pos] && enc_key != CHAR_NUL) ? enc_key : in_char;

  assign mapped_char = (mode == MODE_DECODE) ? dec_char : enc_char;

endmodule

FILE: rtl/keyed_letter_substitution_top.sv
// Keyed letter substitution: translates one character byte per transaction.
// Input channel: in_valid/in_ready carrying mode (0 encode, 1 decode) and
// in_char. Output channel: out_valid/out_ready carrying res_char.
// Configuration: cfg_we/cfg_index/cfg_wdata write key words 0..6 and key_len
// (index 7); write only while no transaction is in flight.
// Path: a character accepted into the input register is translated on its way
// into the result register, where it is held until taken; a stall at the output
// can hold it in either (input register, then result register).
// Throughput: one character per cycle while out_ready does not stall the output;
// the 52 key compares and the lowest match pick lie between the two registers.
// Stall: when out_ready is low the result register holds its transaction,
// and the input register still takes one more character, so in_ready only
// drops once both registers are full.
// Reset: rst, synchronous and active high, empties both registers and
// clears the key table and key_len to zero (every byte then passes through).
module keyed_letter_substitution_top
  import ksub_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   mode,
  input  logic [7:0]             in_char,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             res_char
);

  key_cfg_t   key_cfg;
  logic       s1_valid;
  logic       s1_mode;
  logic [7:0] s1_char;
  logic       s1_adv;
  logic [7:0] xlat_char;

  ksub_keyregs u_keyregs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .key_cfg   (key_cfg)
  );

  ksub_xlat u_xlat (
    .key_cfg     (key_cfg),
    .mode        (s1_mode),
    .in_char     (s1_char),
    .mapped_char (xlat_char)
  );

  // Advance the input stage whenever the result register is free or draining
  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;

  // Input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mode <= mode;
      s1_char <= in_char;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      res_char <= xlat_char;
    end
  end

`ifndef SYNTH
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !s1_valid && !out_valid)
    else $error("pipeline not empty after reset");

  a_accept_loads_s1: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted transaction missing from input register");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_char) && $stable(s1_mode))
    else $error("input register lost a stalled transaction");

  a_zero_len_passes: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_adv && key_cfg.len == '0 |=> out_valid && res_char == $past(s1_char))
    else $error("character altered with no active mappings");
`endif

endmodule

FILE: sim/keyed_letter_substitution_top_test.sv
`timescale 1ns / 100ps

module keyed_letter_substitution_top_test;
  import ksub_pkg::*;

  localparam int NUM_CFG_REGS = REG_KEY_LEN + 1;
  localparam int NUM_KEY_WORDS = REG_KEY_WORD_6 + 1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0 = '0;
  localparam int STALL_HOLD_CYCLES = 120;

  typedef enum int {
    KEY_SHUFFLED,
    KEY_SPARSE,
    KEY_RANDOM,
    KEY_ALL_ZERO,
    KEY_ALL_ONES
  } key_kind_t;

  typedef logic [NUM_KEY_WORDS-1:0][CFG_DATA_W-1:0] key_image_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   mode = MODE_ENCODE;
  logic [7:0]             in_char = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             res_char;

  // Local copy of the key table and active length
  key_image_t       model_key_words = '0;
  logic [LEN_W-1:0] model_key_len = '0;

  byte_t pending_chars[$];
  int    sender_idle_pct = 0;
  int    receiver_stall_pct = 0;
  int    hold_left = 0;
  int    items_sent = 0;
  int    results_checked = 0;
  int    mismatches = 0;
  int    key_settings = 0;

  keyed_letter_substitution_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .in_char   (in_char),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_char  (res_char)
  );

  always #5 clk = ~clk;

  // Letter at a table position: upper case first, then lower case
  function automatic byte_t letter_of(input int pos);
    if (pos < LETTER_COUNT) begin
      return CHAR_UPPER_A + 8'(pos);
    end
    return CHAR_LOWER_A + 8'(pos - LETTER_COUNT);
  endfunction

  function automatic byte_t key_byte(input int pos);
    return model_key_words[pos / 8][8 * (pos % 8) +: 8];
  endfunction

  function automatic int active_count();
    if (model_key_len > ALPHABET_SIZE) begin
      return ALPHABET_SIZE;
    end
    return int'(model_key_len);
  endfunction

  // Expected output byte for one transaction under the current key
  function automatic byte_t predict_char(input logic m, input byte_t c);
    int n;
    byte_t kb;
    n = active_count();
    for (int i = 0; i < n; i++) begin
      kb = key_byte(i);
      if (m == MODE_ENCODE) begin
        if (letter_of(i) == c) begin
          return (kb != CHAR_NUL) ? kb : c;
        end
      end else if (kb == c) begin
        return letter_of(i);
      end
    end
    return c;
  endfunction

  // Mirror a register write into the local key copy
  function automatic void store_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_KEY_LEN: begin
        model_key_len = data[LEN_W-1:0];
      end
      REG_KEY_WORD_6: begin
        model_key_words[REG_KEY_WORD_6] = {32'b0, data[31:0]};
      end
      default: begin
        model_key_words[idx] = data;
      end
    endcase
  endfunction

  // Favour letters in encode and live key bytes in decode, with some noise
  function automatic byte_t pick_char(input logic m);
    int r;
    int n;
    int p;
    r = $urandom_range(99);
    n = active_count();
    if (r < 70 && n > 0) begin
      p = $urandom_range(n - 1);
      return (m == MODE_ENCODE) ? letter_of(p) : key_byte(p);
    end else if (r < 75) begin
      return CHAR_NUL;
    end
    return byte_t'($urandom_range(255));
  endfunction

  // Hold off the output for a counted stretch, else stall at random
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Compare each output transaction with the oldest expected byte
  always @(posedge clk) begin
    byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected output transaction, res_char=%h", $realtime, res_char);
        end
      end else begin
        want = pending_chars.pop_front();
        results_checked++;
        if (res_char !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: res_char mismatch, expected %h, got %h",
                     $realtime, want, res_char);
          end
        end
      end
    end
  end

  // Offer one character, idling first at the current rate
  task automatic send_char(input logic m, input byte_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    in_char <= c;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pending_chars.push_back(predict_char(m, c));
    items_sent++;
  endtask

  // Drop valid and wait until every expected byte has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Write all key words and the length in consecutive cycles
  task automatic program_key(input key_image_t words, input logic [CFG_DATA_W-1:0] len_data);
    logic [CFG_DATA_W-1:0] data;
    for (int w = 0; w < NUM_CFG_REGS; w++) begin
      data = (w == REG_KEY_LEN) ? len_data : words[w];
      cfg_we <= 1'b1;
      cfg_index <= REG_KEY_WORD_0 + CFG_INDEX_W'(w);
      cfg_wdata <= data;
      @(posedge clk);
      store_reg(REG_KEY_WORD_0 + CFG_INDEX_W'(w), data);
    end
    cfg_we <= 1'b0;
    key_settings++;
  endtask

  // Build a key image; bits above the last byte carry junk to be masked
  task automatic build_key(input key_kind_t kind, output key_image_t words);
    byte_t kb[ALPHABET_SIZE];
    byte_t tmp;
    int j;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      kb[i] = letter_of(i);
    end
    for (int i = ALPHABET_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = kb[i];
      kb[i] = kb[j];
      kb[j] = tmp;
    end
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      case (kind)
        KEY_SPARSE: begin
          if ($urandom_range(7) == 0) begin
            kb[i] = CHAR_NUL;
          end else if ($urandom_range(7) == 0) begin
            kb[i] = kb[$urandom_range(ALPHABET_SIZE - 1)];
          end
        end
        KEY_RANDOM: kb[i] = byte_t'($urandom_range(255));
        KEY_ALL_ZERO: kb[i] = CHAR_NUL;
        KEY_ALL_ONES: kb[i] = 8'hFF;
        default: ;
      endcase
    end
    words = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      words[i / 8][8 * (i % 8) +: 8] = kb[i];
    end
    words[REG_KEY_WORD_6][63:32] = $urandom;
  endtask

  // Length word: half the time the full alphabet, else zero, above the limit or partial
  function automatic logic [CFG_DATA_W-1:0] random_len_word();
    logic [CFG_DATA_W-1:0] data;
    int r;
    data = {$urandom, $urandom};
    r = $urandom_range(9);
    if (r < 5) begin
      data[LEN_W-1:0] = LEN_W'(ALPHABET_SIZE);
    end else if (r == 5) begin
      data[LEN_W-1:0] = '0;
    end else if (r == 6) begin
      data[LEN_W-1:0] = '1;
    end else if (r == 7) begin
      data[LEN_W-1:0] = LEN_W'($urandom_range(63, ALPHABET_SIZE + 1));
    end else begin
      data[LEN_W-1:0] = LEN_W'($urandom_range(ALPHABET_SIZE - 1, 1));
    end
    return data;
  endfunction

  function automatic key_kind_t random_kind();
    int r;
    r = $urandom_range(99);
    if (r < 50) return KEY_SHUFFLED;
    if (r < 75) return KEY_SPARSE;
    if (r < 90) return KEY_RANDOM;
    if (r < 95) return KEY_ALL_ZERO;
    return KEY_ALL_ONES;
  endfunction

  // After reset the table is empty, so every byte passes through
  task automatic test_reset_passthrough();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_char(MODE_ENCODE, CHAR_UPPER_A);
    send_char(MODE_DECODE, CHAR_NUL);
    send_char(MODE_ENCODE, 8'hFF);
    drain();
  endtask

  // Table ends, neighbours of the letter ranges, zero and duplicate key bytes
  task automatic test_directed_extremes();
    key_image_t words;
    logic [CFG_DATA_W-1:0] len_data;
    build_key(KEY_SHUFFLED, words);
    words[0][8 * 3 +: 8] = CHAR_NUL;
    words[20 / 8][8 * (20 % 8) +: 8] = words[10 / 8][8 * (10 % 8) +: 8];
    words[51 / 8][8 * (51 % 8) +: 8] = 8'hFF;
    len_data = '1;
    program_key(words, len_data);
    send_char(MODE_ENCODE, CHAR_UPPER_A);
    send_char(MODE_ENCODE, CHAR_UPPER_Z);
    send_char(MODE_ENCODE, CHAR_LOWER_A);
    send_char(MODE_ENCODE, CHAR_LOWER_Z);
    send_char(MODE_ENCODE, letter_of(3));
    send_char(MODE_ENCODE, CHAR_NUL);
    send_char(MODE_ENCODE, 8'hFF);
    send_char(MODE_ENCODE, CHAR_UPPER_A - 8'd1);
    send_char(MODE_ENCODE, CHAR_UPPER_Z + 8'd1);
    send_char(MODE_ENCODE, CHAR_LOWER_A - 8'd1);
    send_char(MODE_ENCODE, CHAR_LOWER_Z + 8'd1);
    send_char(MODE_DECODE, key_byte(0));
    send_char(MODE_DECODE, key_byte(51));
    send_char(MODE_DECODE, key_byte(10));
    send_char(MODE_DECODE, CHAR_NUL);
    send_char(MODE_DECODE, 8'h80);
    drain();
    // Shrink to one pair: everything past the first position drops out
    len_data = {$urandom, $urandom};
    len_data[LEN_W-1:0] = LEN_W'(1);
    program_key(words, len_data);
    send_char(MODE_ENCODE, CHAR_UPPER_A);
    send_char(MODE_ENCODE, letter_of(1));
    send_char(MODE_DECODE, key_byte(0));
    send_char(MODE_DECODE, key_byte(1));
    drain();
  endtask

  // Random traffic with a fresh key every so often
  task automatic test_random_traffic(input int idle, input int stall, input int count);
    key_image_t words;
    logic m;
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        drain();
        build_key(random_kind(), words);
        program_key(words, random_len_word());
      end
      m = $urandom_range(1);
      send_char(m, pick_char(m));
    end
    drain();
  endtask

  // Hold the output off long enough that the block must stall its input
  task automatic test_output_backpressure();
    key_image_t words;
    logic [CFG_DATA_W-1:0] len_data;
    logic m;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    build_key(KEY_SHUFFLED, words);
    len_data = {$urandom, $urandom};
    len_data[LEN_W-1:0] = LEN_W'(ALPHABET_SIZE);
    program_key(words, len_data);
    @(negedge clk);
    hold_left = STALL_HOLD_CYCLES;
    for (int i = 0; i < 30; i++) begin
      m = $urandom_range(1);
      send_char(m, pick_char(m));
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_passthrough();
    test_directed_extremes();
    test_random_traffic(0, 0, 100);
    test_random_traffic(82, 0, 100);
    test_random_traffic(0, 82, 100);
    test_random_traffic(38, 38, 100);
    test_output_backpressure();
    repeat (10) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $display("%0d expected bytes never arrived", pending_chars.size());
      mismatches += pending_chars.size();
    end
    $display("Sent %0d characters and checked %0d translations over %0d key settings,",
             items_sent, results_checked, key_settings);
    $display("with sender gaps, output stalls and a %0d-cycle output hold-off.",
             STALL_HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #2000000;
    $display("Timed out with %0d bytes still expected", pending_chars.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ksub_pkg.sv
rtl/ksub_keyregs.sv
rtl/ksub_xlat.sv
rtl/keyed_letter_substitution_top.sv
sim/keyed_letter_substitution_top_test.sv
